// ===== rtl/pids_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pids_pkg;

    // fixed field widths
    localparam int KEY_W    = 10;
    localparam int OWNER_W  = 2;
    localparam int STATUS_W = 2;

    // stream packing widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // default sizing
    localparam int OWNERS_DEF         = 4;
    localparam int KEYS_PER_OWNER_DEF = 256;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOREIGN      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd3;

    // strobes toward the storage block
    typedef struct packed {
        logic rd_en;
        logic stk_we;
        logic mark_we;
        logic mark_wd;
    } pids_mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/partitioned_id_free_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none

// id allocator with one lifo free stack per owner
// owner o owns ids o*KEYS_PER_OWNER .. o*KEYS_PER_OWNER+KEYS_PER_OWNER-1
// input channel (s_): one request per transfer; s_tuser is the request kind
//   (0 allocate, 1 free), s_tdata carries the owner and, for a free, the id
// result channel (m_): exactly one result transfer per request, in order,
//   with the granted id and a status (ok, pool empty, foreign id, already free)
// a request reads the stack top and the free flag at its input transfer; in
//   the execute state the block decides, writes back and loads the result
//   register once that register is empty or m_tready is high
// s_tready is low while a request is in execute, so a new request is not taken
//   until the last one has been executed
// after reset the block runs an initialization sweep over all OWNERS*KEYS_PER_OWNER
//   entries (1024 with the defaults) that fills every stack with its ids, lowest
//   on top, and marks all ids free; s_tready stays low during the sweep
// a result waits in the output register while m_tready is low; one more
//   request can be accepted meanwhile and then holds until the register frees
module partitioned_id_free_stack #(
    parameter int OWNERS         = pids_pkg::OWNERS_DEF,
    parameter int KEYS_PER_OWNER = pids_pkg::KEYS_PER_OWNER_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [pids_pkg::S_TDATA_W-1:0]   s_tdata,  // owner[1:0], key[11:2], zero pad
    input  wire                              s_tuser,  // req_type[0]
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [pids_pkg::M_TDATA_W-1:0]   m_tdata   // granted_key[9:0], status[11:10], zero pad
);
    import pids_pkg::*;

    localparam int TOTAL = OWNERS * KEYS_PER_OWNER;
    localparam int AW    = $clog2(TOTAL);
    localparam int OIW   = (OWNERS > 1) ? $clog2(OWNERS) : 1;
    localparam int IW    = $clog2(KEYS_PER_OWNER);
    localparam int CW    = $clog2(KEYS_PER_OWNER + 1);

    // controller states
    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg, state_next;

    // init sweep counters
    logic [AW-1:0] init_addr_reg;
    logic [IW-1:0] init_i_reg;
    logic [AW-1:0] init_base_reg;
    logic [AW-1:0] init_val;

    // per-owner stack depth
    logic [CW-1:0] stack_count_reg [OWNERS];

    // request captured at the input transfer
    logic           req_free_reg;
    logic [OIW-1:0] owner_idx_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic           owner_ok_reg;
    logic           key_ok_reg;
    logic [AW-1:0]  key_idx_reg;
    logic [AW-1:0]  push_addr_reg;

    // output register
    logic                m_tvalid_reg;
    logic [KEY_W-1:0]    granted_reg;
    logic [STATUS_W-1:0] status_reg;

    // input unpacking
    logic [OWNER_W-1:0] in_owner;
    logic [KEY_W-1:0]   in_key;
    logic               in_accept;
    logic               in_owner_ok;
    logic               in_key_ok;
    logic [OIW-1:0]     in_owner_idx;
    logic [CW-1:0]      in_cnt;
    logic [AW-1:0]      pop_addr;
    logic [AW-1:0]      push_addr;

    // execute stage
    logic                exec_go;
    logic [CW-1:0]       cnt_cur;
    logic                alloc_ok;
    logic                free_ok;
    logic [STATUS_W-1:0] status_next;
    logic [KEY_W-1:0]    granted_next;

    // memory side
    pids_mem_ctl_t ctl;
    logic [AW-1:0] stk_wa, stk_wd, mark_wa;
    logic [AW-1:0] stk_rd;
    logic          mark_rd;

    assign in_owner     = s_tdata[OWNER_W-1:0];
    assign in_key       = s_tdata[OWNER_W +: KEY_W];
    assign in_accept    = s_tvalid && s_tready;
    assign in_owner_ok  = (32'(in_owner) < OWNERS);
    assign in_owner_idx = OIW'(in_owner);
    assign in_cnt       = in_owner_ok ? stack_count_reg[in_owner_idx] : '0;
    assign pop_addr     = AW'(32'(in_owner_idx) * KEYS_PER_OWNER + 32'(in_cnt) - 32'd1);
    assign push_addr    = AW'(32'(in_owner_idx) * KEYS_PER_OWNER + 32'(in_cnt));

    // id lies inside the requesting owner's block
    assign in_key_ok = (32'(in_key) >= 32'(in_owner) * KEYS_PER_OWNER) &&
                       (32'(in_key) < (32'(in_owner) + 32'd1) * KEYS_PER_OWNER);

    assign s_tready = (state_reg == S_IDLE);
    assign exec_go  = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);

    // reset content of the entry under the sweep
    assign init_val = AW'(32'(init_base_reg) + KEYS_PER_OWNER - 1 - 32'(init_i_reg));

    // decision once the stack top and the free flag are back
    always_comb begin
        cnt_cur      = owner_ok_reg ? stack_count_reg[owner_idx_reg] : '0;
        alloc_ok     = !req_free_reg && owner_ok_reg && (cnt_cur != '0);
        free_ok      = 1'b0;
        granted_next = '0;
        if (req_free_reg == REQ_ALLOC) begin
            status_next = alloc_ok ? ST_OK : ST_EMPTY;
            if (alloc_ok) begin
                granted_next = KEY_W'(stk_rd);
            end
        end else if (!(owner_ok_reg && key_ok_reg)) begin
            status_next = ST_FOREIGN;
        end else if (mark_rd || (32'(cnt_cur) >= KEYS_PER_OWNER)) begin
            status_next = ST_ALREADY_FREE;
        end else begin
            status_next = ST_OK;
            free_ok     = 1'b1;
        end
    end

    // memory port selection: the init sweep or the write-back of a request
    always_comb begin
        ctl.rd_en = in_accept;
        if (state_reg == S_INIT) begin
            ctl.stk_we  = 1'b1;
            ctl.mark_we = 1'b1;
            ctl.mark_wd = 1'b1;
            stk_wa      = init_addr_reg;
            stk_wd      = init_val;
            mark_wa     = init_addr_reg;
        end else begin
            ctl.stk_we  = exec_go && free_ok;
            ctl.mark_we = exec_go && (alloc_ok || free_ok);
            ctl.mark_wd = free_ok;
            stk_wa      = push_addr_reg;
            stk_wd      = key_idx_reg;
            mark_wa     = alloc_ok ? stk_rd : key_idx_reg;
        end
    end

    pids_store #(
        .TOTAL (TOTAL),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .ctl     (ctl),
        .stk_ra  (pop_addr),
        .mark_ra (AW'(in_key)),
        .stk_wa  (stk_wa),
        .stk_wd  (stk_wd),
        .mark_wa (mark_wa),
        .stk_rd  (stk_rd),
        .mark_rd (mark_rd)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: begin
                if (init_addr_reg == AW'(TOTAL - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            init_addr_reg <= '0;
            init_i_reg    <= '0;
            init_base_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int o = 0; o < OWNERS; o++) begin
                stack_count_reg[o] <= CW'(KEYS_PER_OWNER);
            end
        end else begin
            state_reg <= state_next;

            if (state_reg == S_INIT) begin
                init_addr_reg <= init_addr_reg + 1'b1;
                if (init_i_reg == IW'(KEYS_PER_OWNER - 1)) begin
                    init_i_reg    <= '0;
                    init_base_reg <= AW'(32'(init_base_reg) + KEYS_PER_OWNER);
                end else begin
                    init_i_reg <= init_i_reg + 1'b1;
                end
            end

            if (exec_go) begin
                if (alloc_ok) begin
                    stack_count_reg[owner_idx_reg] <= cnt_cur - 1'b1;
                end else if (free_ok) begin
                    stack_count_reg[owner_idx_reg] <= cnt_cur + 1'b1;
                end
            end

            if (exec_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            req_free_reg  <= s_tuser;
            owner_reg     <= in_owner;
            owner_idx_reg <= in_owner_idx;
            owner_ok_reg  <= in_owner_ok;
            key_ok_reg    <= in_key_ok;
            key_idx_reg   <= AW'(in_key);
            push_addr_reg <= push_addr;
        end
        if (exec_go) begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({status_reg, granted_reg});

    // a result only appears right after a request was executed
    a_result_follows_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_EXEC)
        else $error("result raised without an executed request");

    // an accepted request is in the execute state on the next cycle
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> state_reg == S_EXEC)
        else $error("accepted request not in execute");

    // a granted id always comes from the requesting owner's block
    a_grant_in_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_go && alloc_ok) |->
            ((32'(stk_rd) >= 32'(owner_reg) * KEYS_PER_OWNER) &&
             (32'(stk_rd) < (32'(owner_reg) + 32'd1) * KEYS_PER_OWNER)))
        else $error("granted id outside the owner's block");

endmodule

`default_nettype wire

// ===== rtl/pids_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pids_store #(
    parameter int TOTAL = 1024,
    parameter int AW    = 10
) (
    input  wire                       aclk,
    input  pids_pkg::pids_mem_ctl_t   ctl,
    input  wire  [AW-1:0]             stk_ra,
    input  wire  [AW-1:0]             mark_ra,
    input  wire  [AW-1:0]             stk_wa,
    input  wire  [AW-1:0]             stk_wd,
    input  wire  [AW-1:0]             mark_wa,
    output logic [AW-1:0]             stk_rd,
    output logic                      mark_rd
);
    import pids_pkg::*;

    logic [AW-1:0] stk_mem [TOTAL];
    logic          mark_mem [TOTAL];

    logic [AW-1:0] stk_rd_reg;
    logic          mark_rd_reg;

    // stack entries, one region per owner
    always_ff @(posedge aclk) begin
        if (ctl.stk_we) begin
            stk_mem[stk_wa] <= stk_wd;
        end
        if (ctl.rd_en) begin
            stk_rd_reg <= stk_mem[stk_ra];
        end
    end

    // one free flag per id
    always_ff @(posedge aclk) begin
        if (ctl.mark_we) begin
            mark_mem[mark_wa] <= ctl.mark_wd;
        end
        if (ctl.rd_en) begin
            mark_rd_reg <= mark_mem[mark_ra];
        end
    end

    assign stk_rd  = stk_rd_reg;
    assign mark_rd = mark_rd_reg;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pids_pkg::*;

    localparam int OWNERS   = OWNERS_DEF;
    localparam int KPO      = KEYS_PER_OWNER_DEF;
    localparam int TOTAL    = OWNERS * KPO;
    localparam int N_MIXED  = 330;
    localparam int N_DRAIN  = KPO + 3;

    typedef struct packed {
        logic               req;
        logic [OWNER_W-1:0] owner;
        logic [KEY_W-1:0]   key;
    } id_req_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [STATUS_W-1:0] status;
    } grant_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    partitioned_id_free_stack u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the free stacks
    logic [KEY_W-1:0] id_stack [TOTAL];
    int               stack_depth [OWNERS];
    bit               id_is_free [TOTAL];

    id_req_t id_reqs [$];      // requests waiting for the input transfer
    grant_t  grants_due [$];   // results owed by the block, oldest first

    int err_count   = 0;
    int n_accepted  = 0;
    int n_checked   = 0;
    int n_status [4];
    int n_grants    = 0;
    int burst_left  = 1;
    int gap_left    = 0;
    int cycle_cnt   = 0;
    int ready_mode  = 0;

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on result %0d: %s got %0d expected %0d",
                 $time, n_checked, what, got, want);
        err_count++;
    endtask

    function automatic void reset_stacks();
        for (int o = 0; o < OWNERS; o++) begin
            for (int i = 0; i < KPO; i++) begin
                id_stack[o*KPO + i]   = KEY_W'(o*KPO + KPO - 1 - i);
                id_is_free[o*KPO + i] = 1'b1;
            end
            stack_depth[o] = KPO;
        end
    endfunction

    function automatic grant_t predict_grant(id_req_t r);
        grant_t g;
        int     o;
        o        = int'(r.owner);
        g.key    = '0;
        g.status = ST_OK;
        if (r.req == REQ_ALLOC) begin
            if (stack_depth[o] == 0) begin
                g.status = ST_EMPTY;
            end else begin
                stack_depth[o]--;
                g.key = id_stack[o*KPO + stack_depth[o]];
                id_is_free[g.key] = 1'b0;
                n_grants++;
            end
        end else if (int'(r.key) / KPO != o) begin
            g.status = ST_FOREIGN;
        end else if (id_is_free[r.key] || stack_depth[o] >= KPO) begin
            g.status = ST_ALREADY_FREE;
        end else begin
            id_stack[o*KPO + stack_depth[o]] = r.key;
            stack_depth[o]++;
            id_is_free[r.key] = 1'b1;
        end
        n_status[g.status]++;
        return g;
    endfunction

    // random id of the owner's block that is free or held, as asked
    function automatic logic [KEY_W-1:0] find_id(logic [OWNER_W-1:0] o, bit want_free);
        int start;
        int idx;
        start = $urandom_range(0, KPO - 1);
        for (int i = 0; i < KPO; i++) begin
            idx = int'(o)*KPO + (start + i) % KPO;
            if (id_is_free[idx] == want_free)
                return KEY_W'(idx);
        end
        return KEY_W'(int'(o)*KPO + start);
    endfunction

    // driver: bursts of random length, random gaps in between
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                grants_due.push_back(predict_grant(id_reqs.pop_front()));
                n_accepted++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the presented request
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (id_reqs.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tuser  <= id_reqs[0].req;
                s_tdata  <= {{(S_TDATA_W-KEY_W-OWNER_W){1'b0}}, id_reqs[0].key,
                             id_reqs[0].owner};
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks each result in order; the back-pressure pattern is redrawn from four modes as cycle_cnt advances
    always @(posedge aclk) begin
        grant_t want;
        cycle_cnt++;
        if (cycle_cnt % 64 == 0)
            ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (cycle_cnt % 4 == 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
        if (aresetn && m_tvalid && m_tready) begin
            if (grants_due.size() == 0) begin
                report_mismatch("unexpected result, tdata", int'(m_tdata), 0);
            end else begin
                want = grants_due.pop_front();
                if (m_tdata[KEY_W-1:0] != want.key)
                    report_mismatch("granted_key", int'(m_tdata[KEY_W-1:0]), int'(want.key));
                if (m_tdata[KEY_W+STATUS_W-1:KEY_W] != want.status)
                    report_mismatch("status", int'(m_tdata[KEY_W+STATUS_W-1:KEY_W]),
                                    int'(want.status));
                if (m_tdata[M_TDATA_W-1:KEY_W+STATUS_W] != '0)
                    report_mismatch("tdata padding",
                                    int'(m_tdata[M_TDATA_W-1:KEY_W+STATUS_W]), 0);
            end
            n_checked++;
        end
    end

    // stimulus
    initial begin
        id_req_t r;
        int      pick;
        int      wait_cnt;
        logic [OWNER_W-1:0] drain_owner;

        reset_stacks();
        foreach (n_status[i]) n_status[i] = 0;

        // directed: fresh ids in order, lifo reuse, every free reject reason, key extremes
        id_reqs.push_back('{REQ_ALLOC, 2'd0, 10'd0});
        id_reqs.push_back('{REQ_ALLOC, 2'd1, 10'd1023});
        id_reqs.push_back('{REQ_ALLOC, 2'd2, 10'd0});
        id_reqs.push_back('{REQ_ALLOC, 2'd3, 10'd512});
        id_reqs.push_back('{REQ_ALLOC, 2'd0, 10'd0});
        id_reqs.push_back('{REQ_FREE,  2'd0, 10'd0});
        id_reqs.push_back('{REQ_FREE,  2'd0, 10'd0});
        id_reqs.push_back('{REQ_ALLOC, 2'd0, 10'd341});
        id_reqs.push_back('{REQ_FREE,  2'd0, 10'd256});
        id_reqs.push_back('{REQ_FREE,  2'd3, 10'd1023});
        id_reqs.push_back('{REQ_FREE,  2'd3, 10'd0});
        id_reqs.push_back('{REQ_FREE,  2'd0, 10'd1023});
        id_reqs.push_back('{REQ_FREE,  2'd3, 10'd768});
        id_reqs.push_back('{REQ_FREE,  2'd1, 10'd255});
        id_reqs.push_back('{REQ_FREE,  2'd1, 10'd511});
        id_reqs.push_back('{REQ_FREE,  2'd2, 10'd512});
        id_reqs.push_back('{REQ_ALLOC, 2'd3, 10'd682});
        id_reqs.push_back('{REQ_FREE,  2'd1, 10'd256});
        id_reqs.push_back('{REQ_FREE,  2'd2, 10'd767});

        // run one pool dry, a few requests past empty
        drain_owner = OWNER_W'($urandom_range(0, OWNERS - 1));
        for (int i = 0; i < N_DRAIN; i++)
            id_reqs.push_back('{REQ_ALLOC, drain_owner, KEY_W'($urandom_range(0, 1023))});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // mixed traffic, most frees aimed at ids currently handed out
        for (int n = 0; n < N_MIXED; n++) begin
            @(negedge aclk);
            while (id_reqs.size() > 1) @(negedge aclk);
            pick    = $urandom_range(0, 99);
            r.owner = OWNER_W'($urandom_range(0, OWNERS - 1));
            r.key   = KEY_W'($urandom_range(0, 1023));
            r.req   = REQ_FREE;
            if (pick < 45) begin
                r.req = REQ_ALLOC;
            end else if (pick < 80) begin
                r.key = find_id(r.owner, 1'b0);
            end else if (pick < 88) begin
                r.key = find_id(r.owner, 1'b1);
            end else if (pick < 95) begin
                if (r.key[KEY_W-1:KEY_W-OWNER_W] == r.owner)
                    r.owner = r.owner + 1'b1;
            end else begin
                r.req = 1'($urandom_range(0, 1));
            end
            id_reqs.push_back(r);
        end

        while (id_reqs.size() > 0) @(negedge aclk);
        while (grants_due.size() > 0) @(negedge aclk);
        // wait on to catch a stray result
        wait_cnt = 0;
        while (wait_cnt < 20) begin
            @(negedge aclk);
            wait_cnt++;
        end

        $display("requests %0d, results %0d: %0d grants, %0d frees ok, %0d empty pool,",
                 n_accepted, n_checked, n_grants, n_status[ST_OK] - n_grants,
                 n_status[ST_EMPTY]);
        $display("%0d foreign ids, %0d double frees, %0d mismatches",
                 n_status[ST_FOREIGN], n_status[ST_ALREADY_FREE], err_count);
        if (err_count == 0 && grants_due.size() == 0) begin
            $display("** partitioned_id_free_stack: PASSED **");
        end else begin
            $display("** partitioned_id_free_stack: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d requests pending and %0d results owed",
                 id_reqs.size(), grants_due.size());
        $display("** partitioned_id_free_stack: FAILED **");
        $finish;
    end

endmodule
